// ----- rtl/cpte_pkg.sv -----
// ---------------------------------------------------------------------------
// cpte_pkg: shared types and constants
// Widths, request/response payloads and edge codes for the closest point on
// triangle edge pipeline.
// ---------------------------------------------------------------------------
package cpte_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // difference, product and sum widths
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;
    localparam int MW = FRAC_BITS + 1 + DW;

    // latencies in register stages
    localparam int EDGE_LAT = 3 + FRAC_BITS + 2;
    localparam int SEL_LAT  = 4;
    localparam int LAT      = 1 + EDGE_LAT + SEL_LAT;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef logic [2:0][COORD_WIDTH-1:0] t_vec;
    typedef logic [2:0][DW-1:0]          t_dvec;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by_coord;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
    } t_tri_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] near_x;
        logic signed [COORD_WIDTH-1:0] near_y;
        logic signed [COORD_WIDTH-1:0] near_z;
        logic [1:0]                    edge_sel;
    } t_near_rsp;

    // per-edge context carried down the pipeline
    typedef struct packed {
        t_vec          s;
        t_vec          e;
        t_vec          p;
        t_dvec         v;
        logic [SW-1:0] d;
        logic          use_e;
    } t_edge_ctx;

endpackage

// ----- rtl/cpte_tri_if.sv -----
// ---------------------------------------------------------------------------
// cpte_tri_if / cpte_near_if: valid/ready channels
// Request channel carries a triangle and query point, response channel the
// nearest boundary point.
// ---------------------------------------------------------------------------
interface cpte_tri_if;
    logic                valid;
    logic                ready;
    cpte_pkg::t_tri_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpte_near_if;
    logic                valid;
    logic                ready;
    cpte_pkg::t_near_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/closest_point_on_triangle_edge.sv -----
// Throughput: one request per cycle while the response is not stalled; the divider is 16 one-bit stages per edge.
// The whole pipeline advances together and holds while the response waits.
// Reset: synchronous, active low; clears all stage valid bits, payload is
// not reset.
// ---------------------------------------------------------------------------
// closest_point_on_triangle_edge: nearest point on a triangle boundary
// Edge projection pipelines for edges AB, BC and CA feed a distance compare and select block.
// ---------------------------------------------------------------------------
module closest_point_on_triangle_edge (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpte_tri_if.sink     i_req,
    cpte_near_if.source  o_rsp
);
    localparam int LAT = cpte_pkg::LAT;

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    cpte_pkg::t_tri_req r_in;

    // pipeline advances unless the response is stalled
    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_req.data;
        end
    end

    cpte_pkg::t_vec w_a, w_b, w_c, w_p;
    assign w_a = {r_in.az, r_in.ay, r_in.ax};
    assign w_b = {r_in.bz, r_in.by_coord, r_in.bx};
    assign w_c = {r_in.cz, r_in.cy, r_in.cx};
    assign w_p = {r_in.pz, r_in.py, r_in.px};

    cpte_pkg::t_vec w_q0, w_q1, w_q2, w_p0, w_p1, w_p2;

    cpte_edge u_edge_ab (
        .i_clk(i_clk), .i_en(w_en), .i_s(w_a), .i_e(w_b), .i_p(w_p),
        .o_q(w_q0), .o_p(w_p0)
    );
    cpte_edge u_edge_bc (
        .i_clk(i_clk), .i_en(w_en), .i_s(w_b), .i_e(w_c), .i_p(w_p),
        .o_q(w_q1), .o_p(w_p1)
    );
    cpte_edge u_edge_ca (
        .i_clk(i_clk), .i_en(w_en), .i_s(w_c), .i_e(w_a), .i_p(w_p),
        .o_q(w_q2), .o_p(w_p2)
    );

    // all three carry the same point; take a bitwise blend to use each copy
    cpte_pkg::t_vec w_pq;
    assign w_pq = w_p0 & w_p1 & w_p2;

    cpte_select u_select (
        .i_clk(i_clk), .i_en(w_en),
        .i_q0(w_q0), .i_q1(w_q1), .i_q2(w_q2), .i_p(w_pq),
        .o_rsp(o_rsp.data)
    );

    assign o_rsp.valid = r_vld[LAT-1];

endmodule

// ----- rtl/cpte_edge.sv -----
// ---------------------------------------------------------------------------
// cpte_edge: projection of a point onto one segment
// Differences, dot products, restoring division one quotient bit per stage,
// then scale and offset. EDGE_LAT stages, one request per cycle while i_en is high.
// ---------------------------------------------------------------------------
module cpte_edge (
    input  logic          i_clk,
    input  logic          i_en,
    input  cpte_pkg::t_vec i_s,
    input  cpte_pkg::t_vec i_e,
    input  cpte_pkg::t_vec i_p,
    output cpte_pkg::t_vec o_q,
    output cpte_pkg::t_vec o_p
);
    localparam int CW = cpte_pkg::COORD_WIDTH;
    localparam int FB = cpte_pkg::FRAC_BITS;
    localparam int DW = cpte_pkg::DW;
    localparam int PW = cpte_pkg::PW;
    localparam int SW = cpte_pkg::SW;
    localparam int MW = cpte_pkg::MW;

    // stage 1: edge vector and offset of P
    cpte_pkg::t_edge_ctx r_c1;
    cpte_pkg::t_dvec     r_w1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1.s     <= i_s;
            r_c1.e     <= i_e;
            r_c1.p     <= i_p;
            r_c1.d     <= '0;
            r_c1.use_e <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_c1.v[k] <= DW'($signed(i_e[k]) - $signed(i_s[k]));
                r_w1[k]   <= DW'($signed(i_p[k]) - $signed(i_s[k]));
            end
        end
    end

    // stage 2: component products
    cpte_pkg::t_edge_ctx   r_c2;
    logic [2:0][PW-1:0]    r_vv2;
    logic [2:0][PW-1:0]    r_vw2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2 <= r_c1;
            for (int k = 0; k < 3; k++) begin
                r_vv2[k] <= PW'($signed(r_c1.v[k]) * $signed(r_c1.v[k]));
                r_vw2[k] <= PW'($signed(r_c1.v[k]) * $signed(r_w1[k]));
            end
        end
    end

    // stage 3: dot sums and clamp decision
    logic signed [SW:0]  n_num;
    logic [SW-1:0]       n_den;
    logic                n_nonpos;
    logic                n_ge;
    cpte_pkg::t_edge_ctx n_c3;
    always_comb begin
        n_num = (SW+1)'($signed(r_vw2[0])) + (SW+1)'($signed(r_vw2[1]))
              + (SW+1)'($signed(r_vw2[2]));
        n_den = SW'($signed(r_vv2[0])) + SW'($signed(r_vv2[1]))
              + SW'($signed(r_vv2[2]));
        n_nonpos = (n_num <= 0);
        n_ge     = !n_nonpos && ($unsigned(n_num) >= {1'b0, n_den});
        n_c3       = r_c2;
        n_c3.d     = n_den;
        n_c3.use_e = n_ge;
    end

    cpte_pkg::t_edge_ctx r_cd [0:FB];
    logic [SW-1:0]       r_rem [0:FB];
    logic [FB-1:0]       r_t [0:FB];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cd[0]  <= n_c3;
            r_rem[0] <= (n_nonpos || n_ge) ? '0 : n_num[SW-1:0];
            r_t[0]   <= '0;
        end
    end

    // division: one quotient bit per stage
    for (genvar j = 0; j < FB; j++) begin : g_div
        logic [SW:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[j], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_cd[j].d});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cd[j+1]  <= r_cd[j];
                r_rem[j+1] <= w_ge ? SW'(w_sh - {1'b0, r_cd[j].d}) : w_sh[SW-1:0];
                r_t[j+1]   <= {r_t[j][FB-2:0], w_ge};
            end
        end
    end

    // scale edge vector by the fraction
    cpte_pkg::t_edge_ctx r_cm;
    logic [2:0][MW-1:0]  r_prod;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cm <= r_cd[FB];
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= MW'($signed({1'b0, r_t[FB]}) * $signed(r_cd[FB].v[k]));
            end
        end
    end

    // offset from the start point, or the end point when clamped
    cpte_pkg::t_vec r_q;
    cpte_pkg::t_vec r_p;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_cm.p;
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= r_cm.use_e ? r_cm.e[k]
                        : CW'(MW'($signed(r_cm.s[k])) + ($signed(r_prod[k]) >>> FB));
            end
        end
    end

    assign o_q = r_q;
    assign o_p = r_p;

endmodule

// ----- rtl/cpte_select.sv -----
// ---------------------------------------------------------------------------
// cpte_select: nearest of the AB, BC and CA edge points
// Differences, squares, sums, then compare and select into the response
// register. SEL_LAT stages.
// ---------------------------------------------------------------------------
module cpte_select (
    input  logic                i_clk,
    input  logic                i_en,
    input  cpte_pkg::t_vec      i_q0,
    input  cpte_pkg::t_vec      i_q1,
    input  cpte_pkg::t_vec      i_q2,
    input  cpte_pkg::t_vec      i_p,
    output cpte_pkg::t_near_rsp o_rsp
);
    localparam int DW = cpte_pkg::DW;
    localparam int PW = cpte_pkg::PW;
    localparam int SW = cpte_pkg::SW;

    cpte_pkg::t_vec r_q1 [0:2];
    cpte_pkg::t_vec r_q2 [0:2];
    cpte_pkg::t_vec r_q3 [0:2];
    cpte_pkg::t_dvec    r_df [0:2];
    logic [2:0][PW-1:0] r_sq [0:2];
    logic [SW-1:0]      r_ds [0:2];

    // stages 1 to 3: offset, square, sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1[0] <= i_q0;
            r_q1[1] <= i_q1;
            r_q1[2] <= i_q2;
            for (int k = 0; k < 3; k++) begin
                r_df[0][k] <= DW'($signed(i_q0[k]) - $signed(i_p[k]));
                r_df[1][k] <= DW'($signed(i_q1[k]) - $signed(i_p[k]));
                r_df[2][k] <= DW'($signed(i_q2[k]) - $signed(i_p[k]));
            end
            for (int m = 0; m < 3; m++) begin
                r_q2[m] <= r_q1[m];
                r_q3[m] <= r_q2[m];
                for (int k = 0; k < 3; k++) begin
                    r_sq[m][k] <= PW'($signed(r_df[m][k]) * $signed(r_df[m][k]));
                end
                r_ds[m] <= SW'(r_sq[m][0]) + SW'(r_sq[m][1]) + SW'(r_sq[m][2]);
            end
        end
    end

    // stage 4: least distance, ties to the earlier edge
    logic [1:0]     n_sel;
    cpte_pkg::t_vec n_q;
    always_comb begin
        if (!(r_ds[1] < r_ds[0])) begin
            n_sel = !(r_ds[2] < r_ds[0]) ? cpte_pkg::EDGE_AB : cpte_pkg::EDGE_CA;
        end else begin
            n_sel = !(r_ds[2] < r_ds[1]) ? cpte_pkg::EDGE_BC : cpte_pkg::EDGE_CA;
        end
        case (n_sel)
            cpte_pkg::EDGE_AB: n_q = r_q3[0];
            cpte_pkg::EDGE_BC: n_q = r_q3[1];
            default:           n_q = r_q3[2];
        endcase
    end

    cpte_pkg::t_near_rsp r_rsp;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp.near_x   <= n_q[0];
            r_rsp.near_y   <= n_q[1];
            r_rsp.near_z   <= n_q[2];
            r_rsp.edge_sel <= n_sel;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- rtl/cpte_checker.sv -----
// ---------------------------------------------------------------------------
// cpte_checker: port-level checks
// Reset, stall and output code checks, bound to the top level.
// ---------------------------------------------------------------------------
module cpte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_edge_sel,
    input cpte_pkg::t_near_rsp i_out_data
);
    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("response valid after reset");

    // request side stalls only behind a stalled response
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("request stalled without cause");

    // edge code is never the unused value
    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_edge_sel == cpte_pkg::EDGE_AB || i_edge_sel == cpte_pkg::EDGE_BC
                         || i_edge_sel == cpte_pkg::EDGE_CA))
        else $error("bad edge code");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled response changed");
endmodule

bind closest_point_on_triangle_edge cpte_checker u_cpte_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_edge_sel(o_rsp.data.edge_sel),
    .i_out_data(o_rsp.data)
);
